FILE: rtl/clcd_pkg.sv
// Shared types and constants for the character LCD nibble bus controller.
// No dependencies; the modules refer to it by scoped names.
package clcd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WAIT_US = 2'd2;

    localparam logic [7:0]  TICKS_PER_US_RST = 8'd50;
    localparam logic [15:0] POLL_LIMIT_RST   = 16'd16000;
    localparam logic [14:0] INIT_WAIT_US_RST = 15'd20000;

    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_WRITE_CMD = 3'd1;
    localparam logic [2:0] ACT_WRITE_DAT = 3'd2;
    localparam logic [2:0] ACT_SET_POS   = 3'd3;
    localparam logic [2:0] ACT_INIT      = 3'd4;

    localparam logic [7:0] DDRAM_SET = 8'h80;
    localparam logic [7:0] ROW2_OFS  = 8'h40;
    localparam logic [1:0] ROW_TWO   = 2'd2;

    localparam logic [2:0] STEP_LAST_NIB3 = 3'd3;
    localparam logic [2:0] STEP_CMD_FIRST = 3'd4;
    localparam logic [2:0] STEP_CMD_END   = 3'd7;

    localparam logic [3:0] NIB_WAKE = 4'h3;
    localparam logic [3:0] NIB_4BIT = 4'h2;

    typedef enum logic [1:0] {
        REQ_NONE,
        REQ_WRITE,
        REQ_INIT
    } req_kind_t;

    typedef struct packed {
        req_kind_t  kind;
        logic [7:0] byte_value;
        logic       is_data;
        logic       busy;
    } item_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_I_EN,
        PH_I_WAIT,
        PH_W_HI_EN,
        PH_W_HI_GAP,
        PH_W_LO_EN,
        PH_P_SETUP,
        PH_P_EN1,
        PH_P_GAP,
        PH_P_EN2
    } phase_t;

    typedef struct packed {
        logic [7:0]  ticks_per_us;
        logic [15:0] poll_limit;
        logic [14:0] init_wait_us;
    } cfg_t;

    typedef struct packed {
        logic       lcd_en;
        logic       lcd_rs;
        logic       lcd_rw;
        logic [3:0] nibble_out;
        logic       drive_bus;
        logic       ready_res;
        logic       timed_out;
    } res_t;

    // power-up command list: function set, entry mode, display on, clear
    function automatic logic [7:0] boot_cmd(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h28;
            2'd1:    c = 8'h06;
            2'd2:    c = 8'h0C;
            default: c = 8'h01;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/clcd_in_if.sv
// Request channel: one word per clock tick of the pin sequencer.
// Depends on nothing.
interface clcd_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] byte_value;
    logic [6:0] column;
    logic [1:0] row;
    logic [3:0] pins_in;

    modport source (output valid, action, byte_value, column, row, pins_in, input ready);
    modport sink   (input valid, action, byte_value, column, row, pins_in, output ready);
endinterface

FILE: rtl/clcd_out_if.sv
// Result channel: pin levels and status, one word per tick.
// Depends on nothing.
interface clcd_out_if;
    logic       valid;
    logic       ready;
    logic       lcd_en;
    logic       lcd_rs;
    logic       lcd_rw;
    logic [3:0] nibble_out;
    logic       drive_bus;
    logic       ready_res;
    logic       timed_out;

    modport source (output valid, lcd_en, lcd_rs, lcd_rw, nibble_out, drive_bus, ready_res,
                    timed_out, input ready);
    modport sink   (input valid, lcd_en, lcd_rs, lcd_rw, nibble_out, drive_bus, ready_res,
                    timed_out, output ready);
endinterface

FILE: rtl/clcd_front.sv
// Front end: takes request words and classifies them for the sequencer.
// Depends on clcd_pkg and clcd_in_if.
module clcd_front
(
    clcd_in_if.sink          req,
    input  logic             full,
    output logic             push,
    output clcd_pkg::item_t  item
);

    logic [7:0] addr;

    assign req.ready = !full;
    assign push      = req.valid && !full;

    always_comb
    begin
        addr = {1'b0, req.column} - 8'd1;
        if (req.row == clcd_pkg::ROW_TWO)
        begin
            addr = addr | clcd_pkg::ROW2_OFS;
        end
        addr = addr | clcd_pkg::DDRAM_SET;
    end

    always_comb
    begin
        item.busy       = req.pins_in[3];
        item.kind       = clcd_pkg::REQ_NONE;
        item.byte_value = req.byte_value;
        item.is_data    = 1'b0;
        unique case (req.action)
            clcd_pkg::ACT_WRITE_CMD:
            begin
                item.kind = clcd_pkg::REQ_WRITE;
            end
            clcd_pkg::ACT_WRITE_DAT:
            begin
                item.kind    = clcd_pkg::REQ_WRITE;
                item.is_data = 1'b1;
            end
            clcd_pkg::ACT_SET_POS:
            begin
                item.kind       = clcd_pkg::REQ_WRITE;
                item.byte_value = addr;
            end
            clcd_pkg::ACT_INIT:
            begin
                item.kind = clcd_pkg::REQ_INIT;
            end
            default:
            begin
                item.kind = clcd_pkg::REQ_NONE;
            end
        endcase
    end

endmodule

FILE: rtl/clcd_queue.sv
// Two-entry queue of classified words between front end and sequencer.
// Depends on clcd_pkg.
module clcd_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  clcd_pkg::item_t  push_item,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output clcd_pkg::item_t  head
);

    clcd_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/clcd_back.sv
// Back end: pin sequencer with microsecond timer, busy polling and power-up
// sequence, plus the result register. Depends on clcd_pkg and clcd_out_if.
module clcd_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  clcd_pkg::cfg_t   cfg,
    input  logic             item_valid,
    input  clcd_pkg::item_t  item,
    output logic             pop,
    clcd_out_if.source       rsp
);

    clcd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  div_reg, div_next;
    logic [14:0] us_reg, us_next;
    logic [15:0] polls_reg, polls_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_data_reg, held_data_next;
    logic [2:0]  init_step_reg, init_step_next;
    logic        busy_reg, busy_next;
    logic        tmo_reg, tmo_next;
    logic        out_valid_reg, out_valid_next;
    clcd_pkg::res_t res_reg, res_next;

    assign pop            = item_valid && (!out_valid_reg || rsp.ready);
    assign out_valid_next = pop || (out_valid_reg && !rsp.ready);

    assign rsp.valid      = out_valid_reg;
    assign rsp.lcd_en     = res_reg.lcd_en;
    assign rsp.lcd_rs     = res_reg.lcd_rs;
    assign rsp.lcd_rw     = res_reg.lcd_rw;
    assign rsp.nibble_out = res_reg.nibble_out;
    assign rsp.drive_bus  = res_reg.drive_bus;
    assign rsp.ready_res  = res_reg.ready_res;
    assign rsp.timed_out  = res_reg.timed_out;

    // pin levels at the start of the tick
    always_comb
    begin
        res_next            = '0;
        res_next.drive_bus  = 1'b1;
        res_next.ready_res  = phase_reg == clcd_pkg::PH_IDLE;
        res_next.timed_out  = tmo_reg;
        unique case (phase_reg) inside
            clcd_pkg::PH_I_EN:
            begin
                res_next.lcd_en     = 1'b1;
                res_next.nibble_out = (init_step_reg < 3'd3) ? clcd_pkg::NIB_WAKE
                                                             : clcd_pkg::NIB_4BIT;
            end
            clcd_pkg::PH_I_WAIT:
            begin
                res_next.nibble_out = (init_step_reg < 3'd2) ? clcd_pkg::NIB_WAKE
                                                             : clcd_pkg::NIB_4BIT;
            end
            clcd_pkg::PH_W_HI_EN:
            begin
                res_next.lcd_en     = 1'b1;
                res_next.lcd_rs     = held_data_reg;
                res_next.nibble_out = held_byte_reg[7:4];
            end
            clcd_pkg::PH_W_HI_GAP:
            begin
                res_next.lcd_rs     = held_data_reg;
                res_next.nibble_out = held_byte_reg[7:4];
            end
            clcd_pkg::PH_W_LO_EN:
            begin
                res_next.lcd_en     = 1'b1;
                res_next.lcd_rs     = held_data_reg;
                res_next.nibble_out = held_byte_reg[3:0];
            end
            clcd_pkg::PH_P_SETUP, clcd_pkg::PH_P_GAP:
            begin
                res_next.lcd_rw    = 1'b1;
                res_next.drive_bus = 1'b0;
            end
            clcd_pkg::PH_P_EN1, clcd_pkg::PH_P_EN2:
            begin
                res_next.lcd_en    = 1'b1;
                res_next.lcd_rw    = 1'b1;
                res_next.drive_bus = 1'b0;
            end
            default:
            begin
                res_next.drive_bus = 1'b1;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        logic [7:0]  tpu;
        logic [14:0] wait_us;
        logic [15:0] limit;
        logic [14:0] us_dec;
        logic [15:0] polls_dec;
        logic [2:0]  step_inc;
        logic        wrap;
        logic        done;
        logic        finish;

        tpu       = (cfg.ticks_per_us == 8'd0) ? 8'd1 : cfg.ticks_per_us;
        wait_us   = (cfg.init_wait_us == 15'd0) ? 15'd1 : cfg.init_wait_us;
        limit     = (cfg.poll_limit == 16'd0) ? 16'd1 : cfg.poll_limit;
        wrap      = ({1'b0, div_reg} + 9'd1) >= {1'b0, tpu};
        us_dec    = (us_reg != 15'd0) ? us_reg - 15'd1 : 15'd0;
        done      = wrap && (us_dec == 15'd0);
        polls_dec = (polls_reg != 16'd0) ? polls_reg - 16'd1 : 16'd0;
        step_inc  = init_step_reg + 3'd1;
        finish    = 1'b0;

        phase_next     = phase_reg;
        div_next       = div_reg;
        us_next        = us_reg;
        polls_next     = polls_reg;
        held_byte_next = held_byte_reg;
        held_data_next = held_data_reg;
        init_step_next = init_step_reg;
        busy_next      = busy_reg;
        tmo_next       = tmo_reg;

        if (phase_reg == clcd_pkg::PH_IDLE)
        begin
            if (item.kind == clcd_pkg::REQ_WRITE)
            begin
                held_byte_next = item.byte_value;
                held_data_next = item.is_data;
                phase_next     = clcd_pkg::PH_W_HI_EN;
                div_next       = 8'd0;
                us_next        = 15'd1;
            end
            else if (item.kind == clcd_pkg::REQ_INIT)
            begin
                init_step_next = 3'd0;
                phase_next     = clcd_pkg::PH_I_EN;
                div_next       = 8'd0;
                us_next        = 15'd1;
            end
        end
        else
        begin
            if (wrap)
            begin
                div_next = 8'd0;
                us_next  = us_dec;
            end
            else
            begin
                div_next = div_reg + 8'd1;
            end

            if (phase_reg == clcd_pkg::PH_P_EN1 && done)
            begin
                busy_next = item.busy;
            end

            if (done)
            begin
                div_next = 8'd0;
                us_next  = 15'd1;
                unique case (phase_reg)
                    clcd_pkg::PH_I_EN:
                    begin
                        phase_next = clcd_pkg::PH_I_WAIT;
                        us_next    = wait_us;
                    end
                    clcd_pkg::PH_I_WAIT:
                    begin
                        if (init_step_reg < clcd_pkg::STEP_LAST_NIB3)
                        begin
                            init_step_next = step_inc;
                            phase_next     = clcd_pkg::PH_I_EN;
                        end
                        else
                        begin
                            init_step_next = clcd_pkg::STEP_CMD_FIRST;
                            held_byte_next = clcd_pkg::boot_cmd(2'd0);
                            held_data_next = 1'b0;
                            phase_next     = clcd_pkg::PH_W_HI_EN;
                        end
                    end
                    clcd_pkg::PH_W_HI_EN:
                    begin
                        phase_next = clcd_pkg::PH_W_HI_GAP;
                    end
                    clcd_pkg::PH_W_HI_GAP:
                    begin
                        phase_next = clcd_pkg::PH_W_LO_EN;
                    end
                    clcd_pkg::PH_W_LO_EN:
                    begin
                        polls_next = limit;
                        phase_next = clcd_pkg::PH_P_SETUP;
                    end
                    clcd_pkg::PH_P_SETUP:
                    begin
                        phase_next = clcd_pkg::PH_P_EN1;
                    end
                    clcd_pkg::PH_P_EN1:
                    begin
                        phase_next = clcd_pkg::PH_P_GAP;
                        us_next    = 15'd2;
                    end
                    clcd_pkg::PH_P_GAP:
                    begin
                        phase_next = clcd_pkg::PH_P_EN2;
                    end
                    clcd_pkg::PH_P_EN2:
                    begin
                        polls_next = polls_dec;
                        if (!busy_reg)
                        begin
                            tmo_next = 1'b0;
                            finish   = 1'b1;
                        end
                        else if (polls_dec == 16'd0)
                        begin
                            tmo_next = 1'b1;
                            finish   = 1'b1;
                        end
                        else
                        begin
                            phase_next = clcd_pkg::PH_P_SETUP;
                        end
                    end
                    default:
                    begin
                        init_step_next = 3'd0;
                        phase_next     = clcd_pkg::PH_IDLE;
                    end
                endcase

                if (finish)
                begin
                    if (init_step_reg >= clcd_pkg::STEP_CMD_FIRST
                        && init_step_reg < clcd_pkg::STEP_CMD_END)
                    begin
                        init_step_next = step_inc;
                        held_byte_next = clcd_pkg::boot_cmd(step_inc[1:0]);
                        held_data_next = 1'b0;
                        phase_next     = clcd_pkg::PH_W_HI_EN;
                    end
                    else
                    begin
                        init_step_next = 3'd0;
                        phase_next     = clcd_pkg::PH_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= clcd_pkg::PH_IDLE;
            div_reg       <= 8'd0;
            us_reg        <= 15'd0;
            polls_reg     <= 16'd0;
            held_byte_reg <= 8'd0;
            held_data_reg <= 1'b0;
            init_step_reg <= 3'd0;
            busy_reg      <= 1'b0;
            tmo_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg     <= phase_next;
                div_reg       <= div_next;
                us_reg        <= us_next;
                polls_reg     <= polls_next;
                held_byte_reg <= held_byte_next;
                held_data_reg <= held_data_next;
                init_step_reg <= init_step_next;
                busy_reg      <= busy_next;
                tmo_reg       <= tmo_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: rtl/char_lcd_nibble_bus_controller_unit.sv
// Top level of the character LCD nibble bus controller: configuration
// registers, front end, queue and pin sequencer. Depends on clcd_pkg,
// clcd_in_if, clcd_out_if, clcd_front, clcd_queue and clcd_back.
//
// Each request word is one clock tick of an HD44780-style 4-bit bus
// sequencer and yields exactly one result word: the pin levels and status
// at the start of that tick. One word is taken and one returned per clock
// cycle; the pin sequencer steps once per word, and a two-word queue plus
// the result register let either side stall without losing ticks. Bus
// timing is counted in words, so ticks_per_us sets how many words make one
// microsecond. Configuration is written through cfg_we/cfg_index/cfg_data
// while idle; indexes beyond the last register are ignored.
module char_lcd_nibble_bus_controller_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    clcd_in_if.sink                            req,
    clcd_out_if.source                         rsp,
    input  logic                               cfg_we,
    input  logic [clcd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    clcd_pkg::cfg_t  cfg_reg, cfg_next;
    clcd_pkg::item_t push_item;
    clcd_pkg::item_t head;
    logic            push;
    logic            pop;
    logic            full;
    logic            not_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                clcd_pkg::CFG_TICKS_PER_US: cfg_next.ticks_per_us = cfg_data[7:0];
                clcd_pkg::CFG_POLL_LIMIT:   cfg_next.poll_limit   = cfg_data;
                clcd_pkg::CFG_INIT_WAIT_US: cfg_next.init_wait_us = cfg_data[14:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_us <= clcd_pkg::TICKS_PER_US_RST;
            cfg_reg.poll_limit   <= clcd_pkg::POLL_LIMIT_RST;
            cfg_reg.init_wait_us <= clcd_pkg::INIT_WAIT_US_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    clcd_front u_front
    (
        .req  (req),
        .full (full),
        .push (push),
        .item (push_item)
    );

    clcd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    clcd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (not_empty),
        .item       (head),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule
